// ===== src/fxaa_pkg.sv =====
// Shared types, constants and helper functions of the edge anti-alias block.
`default_nettype none
package fxaa_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_THR_MIN      = 2'd2;
	localparam logic [1:0] CFG_THR_REL      = 2'd3;

	// floor(n / 255) for any 32-bit n is (n * RECIP_255) >> RECIP_SHIFT
	localparam logic [31:0] RECIP_255   = 32'h8080_8081;
	localparam int          RECIP_SHIFT = 39;
	localparam int          SQRT_STEPS  = 13;
	localparam int          LUMA_MAX    = 4095;
	localparam int          NUM_TAPS    = 9;
	localparam logic [3:0]  TAP_LAST    = 4'd8;

	typedef struct packed {
		logic       opcode;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] x_out;
		logic [7:0] y_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       was_blended;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CEN_RD,
		ST_CEN_CAP,
		ST_RDA,
		ST_RDB,
		ST_SUM,
		ST_MUL,
		ST_SQI,
		ST_SQ,
		ST_STORE,
		ST_AN1,
		ST_AN2,
		ST_EVAL,
		ST_DEC,
		ST_BL_RD,
		ST_BL_CAP,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		FK_CENTER,
		FK_TAP,
		FK_NEG,
		FK_POS,
		FK_BLEND
	} fetch_kind_t;

	typedef struct packed {
		logic        accept;
		logic        rd_en;
		logic        sel_b;
		fetch_kind_t kind;
		logic [3:0]  tap;
		logic        cap_c;
		logic        cap_a;
		logic        cap_sum;
		logic        mul;
		logic        sq_init;
		logic        sq_step;
		logic        store;
		logic        an1;
		logic        an2;
		logic        srch_init;
		logic        eval;
		logic        cap_blend;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic inner;
		logic edge_found;
		logic r1n;
		logic r2n;
		logic r2;
		logic search_last;
		logic blend_go;
		logic out_free;
	} sts_t;

	function automatic logic [15:0] wsum(input logic [23:0] p);
		return 16'(p[23:16]) * 16'd77 + 16'(p[15:8]) * 16'd150 + 16'(p[7:0]) * 16'd29;
	endfunction

	// tap order: centre, down, up, left, right, down-left, up-right, up-left, down-right
	function automatic logic signed [1:0] tap_dx(input logic [3:0] t);
		logic signed [1:0] d;
		unique case (t)
			4'd3, 4'd5, 4'd7: d = -2'sd1;
			4'd4, 4'd6, 4'd8: d = 2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] tap_dy(input logic [3:0] t);
		logic signed [1:0] d;
		unique case (t)
			4'd2, 4'd6, 4'd7: d = -2'sd1;
			4'd1, 4'd5, 4'd8: d = 2'sd1;
			default:          d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic [12:0] abs14(input logic signed [13:0] v);
		logic signed [13:0] a;
		a = (v < 0) ? -v : v;
		return a[12:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/fxaa_edge_antialias_top.sv =====
// Top level of the edge anti-alias block: controller plus datapath.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data   (in_item_t)
// out     | output    | out_valid/out_stall| out_data  (out_item_t)
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A load request is accepted in the idle state. A filter request on the frame border
// reads only the centre pixel; an inner pixel computes each luma from one memory read
// or two, a 32x32 reciprocal multiply, then a 13-step bit-serial square root: nine
// lumas for the neighbourhood and up to 2*(MAX_SEARCH-1) for the search.
// Reset clears control state, the configuration and the output valid flag; frame memory contents are undefined.
// A stalled result waits in the output register while the next request is taken.
`default_nettype none
module fxaa_edge_antialias_top import fxaa_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_SEARCH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fxaa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (in_data.opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	fxaa_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SEARCH (MAX_SEARCH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== src/fxaa_datapath.sv =====
// Datapath: frame memory, luma unit, neighbourhood analysis, edge search and output register.
`default_nettype none
module fxaa_datapath import fxaa_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_SEARCH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_SEARCH + 1);
	localparam int WCAP  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int HCAP  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	logic [8:0]  frame_width_q, frame_height_q;
	logic [11:0] thr_min_q, thr_rel_q;
	logic [7:0]  x_q, y_q;
	logic [23:0] c_q, res_q, rd_q;
	logic        blend_q;
	logic [15:0] acc_q;
	logic [16:0] s2_q;
	logic [63:0] prod_q;
	logic [24:0] sv_q, sbit_q;
	logic [25:0] sres_q;
	logic [11:0] l_q [NUM_TAPS];
	logic [11:0] range_q, mx_q, ln_q, gmax_q;
	logic [15:0] eh_q, ev_q;
	logic        horiz_q, one_q;
	logic [12:0] avg2_q;
	logic [DW-1:0] d1_q, d2_q, cnt_q;
	logic        r1_q, r2_q;
	logic signed [13:0] e1_q, e2_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [23:0] mem [DEPTH];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 9'd256;
			frame_height_q <= 9'd256;
			thr_min_q      <= 12'd127;
			thr_rel_q      <= 12'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				CFG_THR_MIN:      thr_min_q      <= cfg_data;
				CFG_THR_REL:      thr_rel_q      <= cfg_data;
			endcase
		end
	end

	logic [8:0] eff_w, eff_h;
	assign eff_w = (frame_width_q > 9'(WCAP)) ? 9'(WCAP) : frame_width_q;
	assign eff_h = (frame_height_q > 9'(HCAP)) ? 9'(HCAP) : frame_height_q;

	logic inb;
	assign inb = (int'(x_q) < MAX_WIDTH) && (int'(y_q) < MAX_HEIGHT);

	// read coordinates
	function automatic logic signed [10:0] clamp11(input logic signed [10:0] v,
	                                                input logic signed [10:0] hi);
		logic signed [10:0] r;
		if (v < 0) r = 11'sd0;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	logic signed [10:0] xs, ys, nxs, nys, offs, xlim, ylim, px, py;
	always_comb begin
		xs   = $signed({3'b0, x_q});
		ys   = $signed({3'b0, y_q});
		xlim = $signed({2'b0, eff_w}) - 11'sd1;
		ylim = $signed({2'b0, eff_h}) - 11'sd1;
		nxs  = one_q ? xs - 11'sd1 : xs + 11'sd1;
		nys  = one_q ? ys + 11'sd1 : ys - 11'sd1;
		offs = (cmd.kind == FK_NEG) ? -$signed({{(11 - DW){1'b0}}, d1_q})
		                            : $signed({{(11 - DW){1'b0}}, d2_q});
		px = xs;
		py = ys;
		case (cmd.kind)
			FK_CENTER: begin
				px = xs;
				py = ys;
			end
			FK_TAP: begin
				px = xs + 11'(tap_dx(cmd.tap));
				py = ys + 11'(tap_dy(cmd.tap));
			end
			FK_NEG, FK_POS: begin
				if (horiz_q) begin
					px = clamp11(xs + offs, xlim);
					py = cmd.sel_b ? nys : ys;
				end else begin
					py = clamp11(ys + offs, ylim);
					px = cmd.sel_b ? nxs : xs;
				end
			end
			FK_BLEND: begin
				px = horiz_q ? xs : nxs;
				py = horiz_q ? nys : ys;
			end
			default: begin
				px = xs;
				py = ys;
			end
		endcase
	end

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	assign rd_addr = AW'(int'(py[7:0]) * MAX_WIDTH + int'(px[7:0]));
	assign wr_addr = AW'(int'(in_data.y_pos) * MAX_WIDTH + int'(in_data.x_pos));
	assign wr_en   = cmd.accept && (in_data.opcode == OP_LOAD)
	                 && (int'(in_data.x_pos) < MAX_WIDTH) && (int'(in_data.y_pos) < MAX_HEIGHT);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	// luma unit
	logic [25:0] trial;
	logic [11:0] luma_sat;
	logic signed [13:0] e_new;
	assign trial    = sres_q + 26'(sbit_q);
	assign luma_sat = (sres_q > 26'(LUMA_MAX)) ? 12'(LUMA_MAX) : sres_q[11:0];
	assign e_new    = $signed({1'b0, luma_sat, 1'b0}) - $signed({1'b0, avg2_q});

	// analysis
	logic signed [13:0] ls [NUM_TAPS];
	logic signed [13:0] h0, h1, h2, v0, v1, v2;
	logic [11:0] mx_c, mn_c, l1, l2, g1, g2;
	logic signed [13:0] dg1, dg2;
	logic horiz_c, one_c;
	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) ls[i] = $signed({2'b0, l_q[i]});
		h0 = ls[5] + ls[7] - ls[3] - ls[3];
		h1 = ls[1] + ls[2] - ls[0] - ls[0];
		h2 = ls[8] + ls[6] - ls[4] - ls[4];
		v0 = ls[6] + ls[7] - ls[2] - ls[2];
		v1 = ls[3] + ls[4] - ls[0] - ls[0];
		v2 = ls[5] + ls[8] - ls[1] - ls[1];
		mx_c = l_q[0];
		mn_c = l_q[0];
		for (int i = 1; i < 5; i++) begin
			if (l_q[i] > mx_c) mx_c = l_q[i];
			if (l_q[i] < mn_c) mn_c = l_q[i];
		end
		horiz_c = eh_q >= ev_q;
		l1  = horiz_c ? l_q[1] : l_q[3];
		l2  = horiz_c ? l_q[2] : l_q[4];
		dg1 = $signed({2'b0, l1}) - ls[0];
		dg2 = $signed({2'b0, l2}) - ls[0];
		g1  = 12'(abs14(dg1));
		g2  = 12'(abs14(dg2));
		one_c = g1 >= g2;
	end

	logic [13:0] e1_mag2, e2_mag2;
	logic signed [13:0] close_e;
	assign e1_mag2 = {abs14(e1_q), 1'b0};
	assign e2_mag2 = {abs14(e2_q), 1'b0};
	assign close_e = (d1_q < d2_q) ? e1_q : e2_q;

	// per-channel sums for the blend
	logic [8:0] sum_r, sum_g, sum_b;
	assign sum_r = 9'(c_q[23:16]) + 9'(rd_q[23:16]);
	assign sum_g = 9'(c_q[15:8]) + 9'(rd_q[15:8]);
	assign sum_b = 9'(c_q[7:0]) + 9'(rd_q[7:0]);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= in_data.x_pos;
			y_q <= in_data.y_pos;
		end
		if (cmd.cap_c) begin
			c_q     <= inb ? rd_q : 24'd0;
			res_q   <= inb ? rd_q : 24'd0;
			blend_q <= 1'b0;
		end
		if (cmd.cap_a)
			acc_q <= wsum(rd_q);
		if (cmd.cap_sum)
			s2_q <= (cmd.kind == FK_TAP) ? {acc_q, 1'b0} : 17'(acc_q) + 17'(wsum(rd_q));
		if (cmd.mul)
			prod_q <= 64'({s2_q, 15'b0}) * 64'(RECIP_255);
		if (cmd.sq_init) begin
			sv_q   <= prod_q[RECIP_SHIFT +: 25];
			sres_q <= 26'd0;
			sbit_q <= 25'd1 << 24;
		end
		if (cmd.sq_step) begin
			if ({1'b0, sv_q} >= trial) begin
				sv_q   <= sv_q - trial[24:0];
				sres_q <= (sres_q >> 1) + 26'(sbit_q);
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (cmd.store) begin
			case (cmd.kind)
				FK_TAP:  l_q[cmd.tap] <= luma_sat;
				FK_NEG:  e1_q <= e_new;
				FK_POS:  e2_q <= e_new;
				default: ;
			endcase
		end
		if (cmd.an1) begin
			range_q <= mx_c - mn_c;
			mx_q    <= mx_c;
			eh_q    <= 16'(abs14(h0)) + {2'b0, abs14(h1), 1'b0} + 16'(abs14(h2));
			ev_q    <= 16'(abs14(v0)) + {2'b0, abs14(v1), 1'b0} + 16'(abs14(v2));
		end
		if (cmd.an2) begin
			horiz_q <= horiz_c;
			one_q   <= one_c;
			ln_q    <= one_c ? l1 : l2;
			gmax_q  <= one_c ? g1 : g2;
			avg2_q  <= 13'(one_c ? l1 : l2) + 13'(l_q[0]);
		end
		if (cmd.srch_init) begin
			d1_q  <= DW'(1);
			d2_q  <= DW'(1);
			cnt_q <= '0;
			r1_q  <= 1'b0;
			r2_q  <= 1'b0;
		end
		if (cmd.eval) begin
			r1_q  <= sts.r1n;
			r2_q  <= sts.r2n;
			cnt_q <= cnt_q + DW'(1);
			if (!sts.r1n) d1_q <= d1_q + DW'(1);
			if (!sts.r2n) d2_q <= d2_q + DW'(1);
		end
		if (cmd.cap_blend) begin
			res_q   <= {sum_r[8:1], sum_g[8:1], sum_b[8:1]};
			blend_q <= 1'b1;
		end
		if (cmd.out_load)
			out_q <= '{x_out: x_q, y_out: y_q, red_out: res_q[23:16],
			           green_out: res_q[15:8], blue_out: res_q[7:0], was_blended: blend_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_comb begin
		sts.inner = (x_q != 8'd0) && (y_q != 8'd0)
		            && ({1'b0, x_q} + 9'd1 < eff_w) && ({1'b0, y_q} + 9'd1 < eff_h);
		sts.edge_found = !((range_q < thr_min_q)
		                   || ({range_q, 12'b0} < 24'(mx_q) * 24'(thr_rel_q)));
		sts.r1n = e1_mag2 >= {2'b0, gmax_q};
		sts.r2n = e2_mag2 >= {2'b0, gmax_q};
		sts.r2  = r2_q;
		sts.search_last = (cnt_q + DW'(1)) == DW'(MAX_SEARCH - 1);
		sts.blend_go = (d1_q != d2_q) && ((close_e < 0) != (l_q[0] < ln_q));
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== src/fxaa_ctrl.sv =====
// Controller: sequences reads, luma computations, analysis, search and result hand-off.
`default_nettype none
module fxaa_ctrl import fxaa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t      state_q, state_d;
	fetch_kind_t kind_q, kind_d;
	logic [3:0]  tap_q, tap_d, sq_cnt_q, sq_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= FK_CENTER;
			tap_q    <= 4'd0;
			sq_cnt_q <= 4'd0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			tap_q    <= tap_d;
			sq_cnt_q <= sq_cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		tap_d    = tap_q;
		sq_cnt_d = sq_cnt_q;
		cmd      = '0;
		cmd.kind = kind_q;
		cmd.tap  = tap_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (opcode == OP_FILTER) state_d = ST_CEN_RD;
				end
			end
			ST_CEN_RD: begin
				cmd.rd_en = 1'b1;
				cmd.kind  = FK_CENTER;
				state_d   = ST_CEN_CAP;
			end
			ST_CEN_CAP: begin
				cmd.cap_c = 1'b1;
				if (sts.inner) begin
					kind_d  = FK_TAP;
					tap_d   = 4'd0;
					state_d = ST_RDA;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_RDA: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_RDB;
			end
			ST_RDB: begin
				cmd.cap_a = 1'b1;
				cmd.rd_en = (kind_q != FK_TAP);
				cmd.sel_b = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.cap_sum = 1'b1;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SQI;
			end
			ST_SQI: begin
				cmd.sq_init = 1'b1;
				sq_cnt_d    = 4'd0;
				state_d     = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq_step = 1'b1;
				sq_cnt_d    = sq_cnt_q + 4'd1;
				if (sq_cnt_q == 4'(SQRT_STEPS - 1)) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				case (kind_q)
					FK_TAP: begin
						if (tap_q == TAP_LAST) begin
							state_d = ST_AN1;
						end else begin
							tap_d   = tap_q + 4'd1;
							state_d = ST_RDA;
						end
					end
					FK_NEG: begin
						if (!sts.r2) begin
							kind_d  = FK_POS;
							state_d = ST_RDA;
						end else begin
							state_d = ST_EVAL;
						end
					end
					default: state_d = ST_EVAL;
				endcase
			end
			ST_AN1: begin
				cmd.an1 = 1'b1;
				state_d = ST_AN2;
			end
			ST_AN2: begin
				cmd.an2       = 1'b1;
				cmd.srch_init = 1'b1;
				if (sts.edge_found) begin
					kind_d  = FK_NEG;
					state_d = ST_RDA;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if ((sts.r1n && sts.r2n) || sts.search_last) begin
					state_d = ST_DEC;
				end else begin
					kind_d  = sts.r1n ? FK_POS : FK_NEG;
					state_d = ST_RDA;
				end
			end
			ST_DEC: begin
				state_d = sts.blend_go ? ST_BL_RD : ST_FIN;
			end
			ST_BL_RD: begin
				cmd.rd_en = 1'b1;
				cmd.kind  = FK_BLEND;
				state_d   = ST_BL_CAP;
			end
			ST_BL_CAP: begin
				cmd.cap_blend = 1'b1;
				cmd.kind      = FK_BLEND;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded into a busy output register");

	a_filter_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && opcode == OP_FILTER) |=> state_q == ST_CEN_RD)
		else $error("filter request did not start the centre read");

	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> sq_cnt_q <= 4'(SQRT_STEPS - 1))
		else $error("square root ran past its step count");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q <= TAP_LAST)
		else $error("tap index out of range");

endmodule
`default_nettype wire

// ===== sim/fxaa_edge_antialias_checker.sv =====
// Watches the request and result channels, predicts each filtered pixel and compares.
module fxaa_edge_antialias_checker import fxaa_pkg::*; #(
	parameter int SEARCH_STEPS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          pending,
	output int          fail_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	bit [23:0]   pixel_mem [0:65535];
	int          fw, fh, thr_min, thr_rel;
	int          eff_w, eff_h;
	out_item_t   expected_pixels [$];

	function automatic int weigh(bit [23:0] p);
		return 77 * int'(p[23:16]) + 150 * int'(p[15:8]) + 29 * int'(p[7:0]);
	endfunction

	// integer square root of the scaled weighted sum, saturated to Q0.12
	function automatic int luma_of_sum(longint unsigned s2);
		longint unsigned v, root, b;
		v = (s2 << 23) / 65280;
		root = 0;
		b = 64'd1 << 40;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else
				root >>= 1;
			b >>= 2;
		end
		if (root > 4095) root = 4095;
		return int'(root);
	endfunction

	function automatic bit [23:0] px(int x, int y);
		if (x < 0 || y < 0 || x > 255 || y > 255) return 24'd0;
		return pixel_mem[y * 256 + x];
	endfunction

	function automatic int luma_px(int x, int y);
		return luma_of_sum(2 * longint'(weigh(px(x, y))));
	endfunction

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	// luma of the pair of pixels half way toward the steepest neighbour
	function automatic int edge_sample(bit horiz, int x, int y, int nx, int ny, int off);
		int c;
		if (horiz) begin
			c = clip(x + off, eff_w - 1);
			return luma_of_sum(longint'(weigh(px(c, y))) + longint'(weigh(px(c, ny))));
		end
		c = clip(y + off, eff_h - 1);
		return luma_of_sum(longint'(weigh(px(x, c))) + longint'(weigh(px(nx, c))));
	endfunction

	function automatic out_item_t filtered_pixel(int x, int y);
		bit [23:0] c, n, res;
		bit        blended, horiz, one, r1, r2;
		int        lc, ld, lu, ll, lr, mx, mn, rng, ldl, lur, lul, ldr, hgrad, vgrad;
		int        l1, l2, g1, g2, ln, gmax, avg2, nx, ny, d1, d2, e1, e2, i, k, near_e;
		out_item_t o;
		eff_w = (fw > 256) ? 256 : fw;
		eff_h = (fh > 256) ? 256 : fh;
		c = px(x, y);
		res = c;
		blended = 1'b0;
		if (x > 0 && y > 0 && x + 1 < eff_w && y + 1 < eff_h) begin
			lc = luma_px(x, y);
			ld = luma_px(x, y + 1);
			lu = luma_px(x, y - 1);
			ll = luma_px(x - 1, y);
			lr = luma_px(x + 1, y);
			mx = lc;
			mn = lc;
			if (ld > mx) mx = ld;
			if (lu > mx) mx = lu;
			if (ll > mx) mx = ll;
			if (lr > mx) mx = lr;
			if (ld < mn) mn = ld;
			if (lu < mn) mn = lu;
			if (ll < mn) mn = ll;
			if (lr < mn) mn = lr;
			rng = mx - mn;
			if (!(rng < thr_min || longint'(rng) * 4096 < longint'(mx) * thr_rel)) begin
				ldl = luma_px(x - 1, y + 1);
				lur = luma_px(x + 1, y - 1);
				lul = luma_px(x - 1, y - 1);
				ldr = luma_px(x + 1, y + 1);
				hgrad = iabs(ldl + lul - 2 * ll) + 2 * iabs(ld + lu - 2 * lc)
					+ iabs(ldr + lur - 2 * lr);
				vgrad = iabs(lur + lul - 2 * lu) + 2 * iabs(ll + lr - 2 * lc)
					+ iabs(ldl + ldr - 2 * ld);
				horiz = hgrad >= vgrad;
				l1 = horiz ? ld : ll;
				l2 = horiz ? lu : lr;
				g1 = iabs(l1 - lc);
				g2 = iabs(l2 - lc);
				one = g1 >= g2;
				ln = one ? l1 : l2;
				gmax = one ? g1 : g2;
				avg2 = ln + lc;
				nx = horiz ? x : (one ? x - 1 : x + 1);
				ny = horiz ? (one ? y + 1 : y - 1) : y;
				d1 = 1;
				d2 = 1;
				e1 = 2 * edge_sample(horiz, x, y, nx, ny, -d1) - avg2;
				e2 = 2 * edge_sample(horiz, x, y, nx, ny, d2) - avg2;
				r1 = 2 * iabs(e1) >= gmax;
				r2 = 2 * iabs(e2) >= gmax;
				if (!r1) d1++;
				if (!r2) d2++;
				if (!(r1 && r2)) begin
					for (i = 2; i < SEARCH_STEPS; i++) begin
						if (!r1) e1 = 2 * edge_sample(horiz, x, y, nx, ny, -d1) - avg2;
						if (!r2) e2 = 2 * edge_sample(horiz, x, y, nx, ny, d2) - avg2;
						r1 = 2 * iabs(e1) >= gmax;
						r2 = 2 * iabs(e2) >= gmax;
						if (!r1) d1++;
						if (!r2) d2++;
						if (r1 && r2) break;
					end
				end
				if (d1 != d2) begin
					near_e = (d1 < d2) ? e1 : e2;
					if ((near_e < 0) != (lc < ln)) begin
						n = px(nx, ny);
						for (k = 0; k < 3; k++)
							res[8*k +: 8] = 8'((int'(c[8*k +: 8]) + int'(n[8*k +: 8])) >> 1);
						blended = 1'b1;
					end
				end
			end
		end
		o.x_out       = x[7:0];
		o.y_out       = y[7:0];
		o.red_out     = res[23:16];
		o.green_out   = res[15:8];
		o.blue_out    = res[7:0];
		o.was_blended = blended;
		return o;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: mismatch %s expected %0d actual %0d", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			fw = 256;
			fh = 256;
			thr_min = 127;
			thr_rel = 512;
			expected_pixels.delete();
			pending = 0;
			fail_cnt = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  fw = int'(cfg_data[8:0]);
					CFG_FRAME_HEIGHT: fh = int'(cfg_data[8:0]);
					CFG_THR_MIN:      thr_min = int'(cfg_data);
					CFG_THR_REL:      thr_rel = int'(cfg_data);
					default: ;
				endcase
			end
			// retire the result before taking the next request
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h", $time, out_data);
					fail_cnt++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("x_out", want.x_out, out_data.x_out);
					check_field("y_out", want.y_out, out_data.y_out);
					check_field("red_out", want.red_out, out_data.red_out);
					check_field("green_out", want.green_out, out_data.green_out);
					check_field("blue_out", want.blue_out, out_data.blue_out);
					check_field("was_blended", want.was_blended, out_data.was_blended);
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.opcode == OP_LOAD)
					pixel_mem[int'(in_data.y_pos) * 256 + int'(in_data.x_pos)] =
						{in_data.red_in, in_data.green_in, in_data.blue_in};
				else
					expected_pixels.push_back(filtered_pixel(in_data.x_pos, in_data.y_pos));
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== sim/fxaa_edge_antialias_top_tb.sv =====
// Stimulus and verdict for the edge anti-alias block: frame loads, filter requests, config.
module fxaa_edge_antialias_top_tb import fxaa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEARCH = 12;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	int          pending, fail_cnt;

	int          items_sent = 0, filters_sent = 0;
	int          snd_idle = 29, rcv_stall = 76;
	int          ew = 256, eh = 256;
	bit          written [0:65535];
	int          written_q [$];
	int          pat_kind, pat_k, pat_a, pat_b;
	bit [23:0]   col_a, col_b;

	fxaa_edge_antialias_top #(.MAX_SEARCH(SEARCH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fxaa_edge_antialias_checker #(.SEARCH_STEPS(SEARCH)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fail_cnt(fail_cnt)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < rcv_stall);

	initial begin
		#20ms;
		$display("FAIL fxaa_edge_antialias_top");
		$finish;
	end

	task automatic send_request(input in_item_t it);
		if (items_sent < 130) begin
			snd_idle = 29;
			rcv_stall = 76;
		end else if (items_sent < 260) begin
			snd_idle = 76;
			rcv_stall = 29;
		end else begin
			snd_idle = 0;
			rcv_stall = 0;
		end
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic load_pixel(int x, int y, bit [23:0] rgb);
		in_item_t it;
		it.opcode   = OP_LOAD;
		it.x_pos    = x[7:0];
		it.y_pos    = y[7:0];
		it.red_in   = rgb[23:16];
		it.green_in = rgb[15:8];
		it.blue_in  = rgb[7:0];
		send_request(it);
		if (!written[y * 256 + x]) written_q.push_back(y * 256 + x);
		written[y * 256 + x] = 1'b1;
	endtask

	task automatic filter_pixel(int x, int y);
		in_item_t it;
		it.opcode   = OP_FILTER;
		it.x_pos    = x[7:0];
		it.y_pos    = y[7:0];
		it.red_in   = $urandom;
		it.green_in = $urandom;
		it.blue_in  = $urandom;
		send_request(it);
		filters_sent++;
	endtask

	// hold off until the block has drained, then rewrite all four registers
	task automatic set_frame(int w, int h, int tmin, int trel);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w[11:0];
		@(negedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h[11:0];
		@(negedge clk);
		cfg_index <= CFG_THR_MIN;
		cfg_data <= tmin[11:0];
		@(negedge clk);
		cfg_index <= CFG_THR_REL;
		cfg_data <= trel[11:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		ew = ((w & 511) > 256) ? 256 : (w & 511);
		eh = ((h & 511) > 256) ? 256 : (h & 511);
	endtask

	function automatic bit [23:0] pattern_rgb(int x, int y);
		case (pat_kind)
			0:       return 24'($urandom);
			1:       return (x < pat_k) ? col_a : col_b;
			2:       return (y < pat_k) ? col_a : col_b;
			3:       return (x * pat_a + y * pat_b < pat_k) ? col_a : col_b;
			default: return ((x ^ y) & 1) ? col_a : col_b;
		endcase
	endfunction

	function automatic bit is_written(int x, int y);
		if (x < 0 || y < 0 || x > 255 || y > 255) return 1'b1;
		return written[y * 256 + x];
	endfunction

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	// a filter may touch only written pixels: neighbourhood plus both search lines
	function automatic bit filter_safe(int x, int y);
		int d, o;
		if (!written[y * 256 + x]) return 1'b0;
		if (!(x > 0 && y > 0 && x + 1 < ew && y + 1 < eh)) return 1'b1;
		for (d = -1; d <= 1; d++)
			for (o = -SEARCH; o <= SEARCH; o++)
				if (!is_written(clip(x + o, ew - 1), y + d) ||
				    !is_written(x + d, clip(y + o, eh - 1)))
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic random_filter();
		int x, y, idx, tries;
		for (tries = 0; tries < 200; tries++) begin
			if (ew > 0 && eh > 0 && $urandom_range(9) > 2) begin
				x = $urandom_range(ew - 1);
				y = $urandom_range(eh - 1);
			end else begin
				idx = written_q[$urandom_range(written_q.size() - 1)];
				x = idx % 256;
				y = idx / 256;
			end
			if (filter_safe(x, y)) begin
				filter_pixel(x, y);
				return;
			end
		end
	endtask

	task automatic pick_pattern();
		pat_kind = $urandom_range(4);
		col_a = $urandom;
		col_b = $urandom;
		if ($urandom_range(1)) begin
			col_a = 24'h000000;
			col_b = 24'hFFFFFF;
		end
		pat_a = $urandom_range(1, 4);
		pat_b = $urandom_range(1, 4);
		pat_k = $urandom_range(2, 40);
	endtask

	task automatic fill_window(int x0, int x1, int y0, int y1);
		int x, y;
		for (y = y0; y <= y1; y++)
			for (x = x0; x <= x1; x++)
				load_pixel(x, y, pattern_rgb(x, y));
	endtask

	task automatic random_scene();
		int w, h, tmin, trel, sel;
		w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
		h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
		sel = $urandom_range(9);
		if (sel == 0) begin
			tmin = 4095;
			trel = 4095;
		end else if (sel == 1) begin
			tmin = $urandom_range(4095);
			trel = $urandom_range(4095);
		end else begin
			tmin = $urandom_range(160);
			trel = $urandom_range(1024);
		end
		set_frame(w, h, tmin, trel);
		pick_pattern();
		if (ew > 0 && eh > 0) fill_window(0, ew - 1, 0, eh - 1);
		repeat (30) begin
			if ($urandom_range(99) < 15) begin
				if (ew > 0 && eh > 0 && $urandom_range(4) != 0)
					load_pixel($urandom_range(ew - 1), $urandom_range(eh - 1), $urandom);
				else
					load_pixel($urandom_range(255), $urandom_range(255), $urandom);
			end else
				random_filter();
		end
	endtask

	initial begin
		int x, y;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// border pixels under the reset frame size
		load_pixel(0, 0, 24'h000000);
		load_pixel(255, 255, 24'hFFFFFF);
		load_pixel(255, 0, 24'hFF00FF);
		filter_pixel(0, 0);
		filter_pixel(255, 255);
		filter_pixel(255, 0);

		// tiny frame, zero thresholds: every inner pixel sees an edge
		set_frame(5, 4, 0, 0);
		pat_kind = 4;
		col_a = 24'hFFFFFF;
		col_b = 24'h000000;
		fill_window(0, 4, 0, 3);
		for (y = 1; y <= 2; y++)
			for (x = 1; x <= 3; x++)
				filter_pixel(x, y);
		// maximum thresholds leave only a full-range edge; far pixel lies outside the frame
		set_frame(5, 4, 4095, 4095);
		filter_pixel(2, 1);
		filter_pixel(2, 2);
		filter_pixel(255, 255);

		// oversized width clamps to the full row; search runs into the right edge
		set_frame(12'hFFF, 8, 20, 100);
		pick_pattern();
		pat_kind = 3;
		fill_window(230, 255, 0, 3);
		repeat (15) random_filter();

		// full height, search clamps at the bottom row
		set_frame(8, 256, 40, 300);
		pick_pattern();
		pat_kind = 3;
		fill_window(0, 3, 230, 255);
		repeat (15) random_filter();

		while (items_sent < 400) random_scene();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_cnt == 0 && pending == 0)
			$display("PASS fxaa_edge_antialias_top");
		else
			$display("FAIL fxaa_edge_antialias_top");
		$finish;
	end

endmodule

// ===== fxaa_edge_antialias_top.f =====
src/fxaa_pkg.sv
src/fxaa_datapath.sv
src/fxaa_ctrl.sv
src/fxaa_edge_antialias_top.sv
sim/fxaa_edge_antialias_checker.sv
sim/fxaa_edge_antialias_top_tb.sv
